@@ design/sprite_box_collision_table_core_assert.svh @@
// Assertion macros for the checker file.
`ifndef SPRITE_BOX_COLLISION_TABLE_CORE_ASSERT_SVH
`define SPRITE_BOX_COLLISION_TABLE_CORE_ASSERT_SVH

// Check a property outside reset.
`define SBCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SBCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ design/sbct_pkg.sv @@
package sbct_pkg;

    localparam int NUM_SPRITES = 8;
    localparam int CID_W       = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1;
    localparam int IDX_W       = 3;
    localparam int COORD_W     = 8;
    localparam int MASK_W      = 8;
    localparam int BOX_MARGIN  = 3;
    localparam int AXIS_SPAN   = 256;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [1:0] {
        OP_PLACE       = 2'd0,
        OP_DISABLE     = 2'd1,
        OP_DISABLE_ALL = 2'd2,
        OP_READ        = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_WIDTH  = 2'd0,
        REG_BOX_HEIGHT = 2'd1
    } t_reg;

    // Request token that walks the cell chain.
    typedef struct packed {
        logic               vld;
        t_op                op;
        logic [IDX_W-1:0]   idx;
        logic               idx_ok;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [MASK_W-1:0]  acc;
        logic [MASK_W-1:0]  rd;
    } t_tok;

    typedef struct packed {
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
    } t_cfg;

    // Mask write-back for the placed sprite.
    typedef struct packed {
        logic              vld;
        logic [IDX_W-1:0]  idx;
        logic [MASK_W-1:0] mask;
    } t_wb;

endpackage

@@ design/sbct_cell.sv @@
module sbct_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [sbct_pkg::CID_W-1:0]   i_cell_id,
    input  sbct_pkg::t_cfg               i_cfg,
    input  sbct_pkg::t_wb                i_wb,
    input  sbct_pkg::t_tok               i_tok,
    output sbct_pkg::t_tok               o_tok
);

    logic [sbct_pkg::COORD_W-1:0] r_x, n_x;
    logic [sbct_pkg::COORD_W-1:0] r_y, n_y;
    logic                         r_drawn, n_drawn;
    logic [sbct_pkg::MASK_W-1:0]  r_hits, n_hits;
    sbct_pkg::t_tok               r_tok, n_tok;

    logic                         w_self;
    logic                         w_wb_self;
    logic                         w_hit;
    logic [sbct_pkg::MASK_W-1:0]  w_own_bit;

    function automatic logic axis_near(input logic [sbct_pkg::COORD_W-1:0] d,
                                       input logic [sbct_pkg::COORD_W-1:0] size);
        logic [sbct_pkg::COORD_W:0] r;
        logic [sbct_pkg::COORD_W:0] d9;
        r  = {1'b0, size} - (sbct_pkg::COORD_W+1)'(sbct_pkg::BOX_MARGIN);
        d9 = {1'b0, d};
        return ({1'b0, size} > (sbct_pkg::COORD_W+1)'(sbct_pkg::BOX_MARGIN))
            && ((d9 < r) || (d9 > ((sbct_pkg::COORD_W+1)'(sbct_pkg::AXIS_SPAN) - r)));
    endfunction

    assign w_self    = (32'(i_tok.idx) == 32'(i_cell_id));
    assign w_wb_self = i_wb.vld && (32'(i_wb.idx) == 32'(i_cell_id));
    assign w_hit     = r_drawn
                    && axis_near(r_y - i_tok.py, i_cfg.height)
                    && axis_near(r_x - i_tok.px, i_cfg.width);

    // Bit of this sprite in a mask; none past the mask width.
    always_comb begin
        for (int b = 0; b < sbct_pkg::MASK_W; b++) begin
            w_own_bit[b] = (32'(i_cell_id) == b);
        end
    end

    always_comb begin
        n_x     = r_x;
        n_y     = r_y;
        n_drawn = r_drawn;
        n_hits  = r_hits;
        n_tok   = i_tok;
        if (w_wb_self) begin
            n_hits = i_wb.mask;
        end
        if (i_tok.vld) begin
            if (w_self) begin
                n_tok.rd = r_hits;
            end
            case (i_tok.op)
                sbct_pkg::OP_PLACE: begin
                    if (i_tok.idx_ok) begin
                        if (w_self) begin
                            n_x     = i_tok.px;
                            n_y     = i_tok.py;
                            n_drawn = 1'b1;
                            n_hits  = '0;
                        end else if (w_hit) begin
                            n_hits[i_tok.idx] = 1'b1;
                            n_tok.acc         = i_tok.acc | w_own_bit;
                        end
                    end
                end
                sbct_pkg::OP_DISABLE: begin
                    if (i_tok.idx_ok && w_self) begin
                        n_drawn = 1'b0;
                    end
                end
                sbct_pkg::OP_DISABLE_ALL: begin
                    n_drawn = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_y     <= '0;
            r_drawn <= 1'b0;
            r_hits  <= '0;
            r_tok   <= '0;
        end else begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_drawn <= n_drawn;
            r_hits  <= n_hits;
            r_tok   <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ design/sprite_box_collision_table_core.sv @@
// Sprite box collision table. Each of NUM_SPRITES cells holds one sprite's
// position, drawn flag and collision mask. A request enters the head of the
// chain and moves one cell per clock; each cell acts on it as it passes
// (place: compare boxes against the new position and set hit bits; disable:
// clear drawn flags; every op: pick up the addressed sprite's mask). When the
// request leaves the last cell, the mask gathered for a placed sprite is
// written back into its cell and the result is loaded into the output
// register. A request passes through the input register, then each cell's
// register in turn, before its result is loaded into the output register;
// the next request is accepted once that result is loaded and the output
// register is free or being drained. Configuration writes are taken in every
// cycle and must only be issued while no request is in flight.
module sprite_box_collision_table_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,  // [2:0] sprite_index,
                                                           // [10:3] pos_x, [18:11] pos_y
    input  logic [1:0]                      s_axis_tuser,  // [1:0] op
    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // [7:0] collision_mask
    // Configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sbct_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                      i_cfg_data
);

    sbct_pkg::t_cfg              r_cfg;
    sbct_pkg::t_tok              r_tok_in;
    logic                        r_busy;
    logic                        r_out_vld;
    logic [sbct_pkg::MASK_W-1:0] r_out_data;

    sbct_pkg::t_tok              w_tok [sbct_pkg::NUM_SPRITES];
    sbct_pkg::t_tok              w_last;
    sbct_pkg::t_wb               w_wb;
    logic                        w_accept;

    assign s_axis_tready = !r_busy && (!r_out_vld || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign w_last = w_tok[sbct_pkg::NUM_SPRITES-1];

    // Write the gathered mask back into the placed sprite's cell.
    assign w_wb.vld  = w_last.vld && (w_last.op == sbct_pkg::OP_PLACE) && w_last.idx_ok;
    assign w_wb.idx  = w_last.idx;
    assign w_wb.mask = w_last.acc;

    // Configuration registers; writes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= 8'd16;
            r_cfg.height <= 8'd16;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sbct_pkg::REG_BOX_WIDTH:  r_cfg.width  <= i_cfg_data;
                sbct_pkg::REG_BOX_HEIGHT: r_cfg.height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Launch the request, track it through the chain, load the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_in   <= '0;
            r_busy     <= 1'b0;
            r_out_vld  <= 1'b0;
            r_out_data <= '0;
        end else begin
            r_tok_in.vld <= w_accept;
            if (w_accept) begin
                r_tok_in.op     <= sbct_pkg::t_op'(s_axis_tuser);
                r_tok_in.idx    <= s_axis_tdata[2:0];
                r_tok_in.idx_ok <= (32'(s_axis_tdata[2:0]) < sbct_pkg::NUM_SPRITES);
                r_tok_in.px     <= s_axis_tdata[10:3];
                r_tok_in.py     <= s_axis_tdata[18:11];
                r_tok_in.acc    <= '0;
                r_tok_in.rd     <= '0;
                r_busy          <= 1'b1;
            end else if (w_last.vld) begin
                r_busy <= 1'b0;
            end
            if (w_last.vld) begin
                r_out_vld  <= 1'b1;
                r_out_data <= (w_last.op == sbct_pkg::OP_PLACE) ? w_last.acc : w_last.rd;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Cell chain: cell 0 takes the launched request, each later cell its
    // neighbor's.
    for (genvar g = 0; g < sbct_pkg::NUM_SPRITES; g++) begin : g_cell
        sbct_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cell_id (sbct_pkg::CID_W'(g)),
            .i_cfg     (r_cfg),
            .i_wb      (w_wb),
            .i_tok     ((g == 0) ? r_tok_in : w_tok[(g == 0) ? 0 : g-1]),
            .o_tok     (w_tok[g])
        );
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ design/sbct_checker.sv @@
`include "sprite_box_collision_table_core_assert.svh"

module sbct_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [7:0]                      m_axis_tdata
);

    // Hold a stalled result.
    `SBCT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")

    // One request in flight at a time.
    `SBCT_ASSERT(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request accepted while another is in flight")

    // Accept only when the output slot frees up.
    `SBCT_ASSERT(a_out_slot, s_axis_tready && m_axis_tvalid |-> m_axis_tready, "request accepted with output slot full")

    // Reset leaves no result pending.
    `SBCT_ASSERT_ALWAYS(a_rst_out, !i_rst_n |=> !m_axis_tvalid, "result valid right after reset")

endmodule

bind sprite_box_collision_table_core sbct_checker u_sbct_checker (.*);
